// File: hdl/vcu_pkg.sv
`default_nettype none
package vcu_pkg;

  typedef struct packed {
    logic signed [15:0] observed_velocity;
    logic signed [15:0] previous_velocity;
    logic signed [15:0] sounding_velocity;
    logic signed [15:0] above_velocity;
    logic               previous_present;
    logic               sounding_present;
    logic               above_present;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] corrected_velocity;
    logic               accepted;
    logic [1:0]         reference_case;
  } out_item_t;

  typedef enum logic [2:0] {
    CFG_MISSING_CODE = 3'd0,
    CFG_NYQUIST_VEL  = 3'd1,
    CFG_NYQUIST_INT  = 3'd2,
    CFG_COMPARE_FRAC = 3'd3,
    CFG_MIN_ABS_VEL  = 3'd4
  } cfg_idx_t;

  localparam logic [1:0] CASE_NONE     = 2'd0;
  localparam logic [1:0] CASE_SOUNDING = 2'd1;
  localparam logic [1:0] CASE_ABOVE    = 2'd2;
  localparam logic [1:0] CASE_PREVIOUS = 2'd3;

  localparam logic signed [15:0] RST_MISSING_CODE = -16'sd32768;
  localparam logic [13:0]        RST_NYQUIST_VEL  = 14'd1000;
  localparam logic [14:0]        RST_NYQUIST_INT  = 15'd2000;
  localparam logic [8:0]         RST_COMPARE_FRAC = 9'd64;
  localparam logic [14:0]        RST_MIN_ABS_VEL  = 15'd100;

endpackage
`default_nettype wire

// File: hdl/vcu_if.sv
`default_nettype none
interface vcu_in_if;
  import vcu_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface vcu_out_if;
  import vcu_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: hdl/velocity_continuity_unfold.sv
// an input transfer passes through the pipeline stage registers and then the output register to out_ch
// throughput: one item per cycle while out_ch is not stalled, one unfolding step per pipeline stage
// a stall on out_ch holds the whole pipeline, nothing is dropped or repeated
// reset (rst_n low, synchronous) clears all valid bits and loads the
// configuration registers with their default values
`default_nettype none
module velocity_continuity_unfold #(
  parameter int MAX_SHIFTS    = 10,
  parameter int VELOCITY_BITS = 16
) (
  input  wire               clk,
  input  wire               rst_n,
  vcu_in_if.sink            in_ch,
  vcu_out_if.source         out_ch,
  input  wire               cfg_we,
  input  wire [2:0]         cfg_index,
  input  wire [15:0]        cfg_data
);
  import vcu_pkg::*;

  localparam int VW  = (VELOCITY_BITS > 16) ? VELOCITY_BITS : 16;
  localparam int NSH = MAX_SHIFTS + 1;
  localparam longint SAT_HI_L = (64'sd1 <<< (VELOCITY_BITS - 1)) - 64'sd1;
  localparam logic signed [VW:0] SAT_HI = (VW+1)'(SAT_HI_L);
  localparam logic signed [VW:0] SAT_LO = -SAT_HI - 1;

  logic signed [15:0] missing_code_r;
  logic [13:0]        nyq_vel_r;
  logic [14:0]        nyq_int_r;
  logic [8:0]         cmp_frac_r;
  logic [14:0]        min_abs_r;
  logic [22:0]        limit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      missing_code_r <= RST_MISSING_CODE;
      nyq_vel_r      <= RST_NYQUIST_VEL;
      nyq_int_r      <= RST_NYQUIST_INT;
      cmp_frac_r     <= RST_COMPARE_FRAC;
      min_abs_r      <= RST_MIN_ABS_VEL;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_MISSING_CODE: missing_code_r <= cfg_data;
        CFG_NYQUIST_VEL:  nyq_vel_r      <= cfg_data[13:0];
        CFG_NYQUIST_INT:  nyq_int_r      <= cfg_data[14:0];
        CFG_COMPARE_FRAC: cmp_frac_r     <= cfg_data[8:0];
        CFG_MIN_ABS_VEL:  min_abs_r      <= cfg_data[14:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    limit_r <= cmp_frac_r * nyq_vel_r;
  end

  // pipeline state, index 0 is the input stage, NSH is after the last step
  logic                 vld_r  [0:NSH];
  logic signed [VW-1:0] v_r    [0:NSH];
  logic signed [VW-1:0] v_nxt  [0:NSH-1];
  logic signed [15:0]   ref_r  [0:NSH];
  logic signed [15:0]   chk_r  [0:NSH];
  logic [1:0]           case_r [0:NSH];
  logic                 big_r  [0:NSH];

  logic      adv;
  logic      out_vld_r;
  out_item_t out_r;

  assign adv         = !out_vld_r || out_ch.ready;
  assign in_ch.ready = adv;

  // reference selection
  in_item_t           it;
  logic               obs_miss, sound_ok, above_ok, prev_ok;
  logic [1:0]         case_sel;
  logic signed [15:0] ref_sel, chk_sel;
  logic signed [16:0] obs_ext;
  logic [16:0]        obs_abs;

  always_comb begin
    it       = in_ch.data;
    obs_miss = it.observed_velocity == missing_code_r;
    sound_ok = !it.previous_present && it.sounding_present &&
               (it.sounding_velocity != missing_code_r);
    above_ok = it.above_present && (it.above_velocity != missing_code_r);
    prev_ok  = it.previous_present && (it.previous_velocity != missing_code_r);
    case_sel = CASE_NONE;
    ref_sel  = it.sounding_velocity;
    chk_sel  = it.sounding_velocity;
    if (sound_ok && !above_ok) begin
      case_sel = CASE_SOUNDING;
    end else if (sound_ok && above_ok) begin
      case_sel = CASE_ABOVE;
      ref_sel  = it.above_velocity;
    end else if (prev_ok && above_ok) begin
      case_sel = CASE_PREVIOUS;
      ref_sel  = it.previous_velocity;
      chk_sel  = it.above_velocity;
    end
    if (obs_miss) begin
      case_sel = CASE_NONE;
    end
    obs_ext = 17'(it.observed_velocity);
    obs_abs = obs_ext[16] ? 17'(-obs_ext) : obs_ext;
  end

  // one unfolding step per stage
  for (genvar k = 0; k < NSH; k++) begin : g_step
    logic signed [VW:0] diff, sum, sat;
    logic [VW:0]        dmag;
    logic               far;
    always_comb begin
      diff = (VW+1)'(ref_r[k]) - (VW+1)'(v_r[k]);
      dmag = diff[VW] ? (VW+1)'(-diff) : (VW+1)'(diff);
      far  = dmag >= (VW+1)'(nyq_vel_r);
      if (!diff[VW]) begin
        sum = (VW+1)'(v_r[k]) + (VW+1)'($signed({1'b0, nyq_int_r}));
      end else begin
        sum = (VW+1)'(v_r[k]) - (VW+1)'($signed({1'b0, nyq_int_r}));
      end
      if (sum > SAT_HI) begin
        sat = SAT_HI;
      end else if (sum < SAT_LO) begin
        sat = SAT_LO;
      end else begin
        sat = sum;
      end
      v_nxt[k] = far ? sat[VW-1:0] : v_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= NSH; k++) begin
        vld_r[k] <= 1'b0;
      end
    end else if (adv) begin
      vld_r[0] <= in_ch.valid;
      for (int k = 1; k <= NSH; k++) begin
        vld_r[k] <= vld_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      v_r[0]    <= VW'(it.observed_velocity);
      ref_r[0]  <= ref_sel;
      chk_r[0]  <= chk_sel;
      case_r[0] <= case_sel;
      big_r[0]  <= obs_abs > 17'(min_abs_r);
      for (int k = 1; k <= NSH; k++) begin
        v_r[k]    <= v_nxt[k-1];
        ref_r[k]  <= ref_r[k-1];
        chk_r[k]  <= chk_r[k-1];
        case_r[k] <= case_r[k-1];
        big_r[k]  <= big_r[k-1];
      end
    end
  end

  // acceptance
  logic signed [VW:0] fdiff, cdiff;
  logic [VW:0]        fmag, cmag;
  logic               dok, cok, ok;
  out_item_t          res;

  always_comb begin
    fdiff = (VW+1)'(ref_r[NSH]) - (VW+1)'(v_r[NSH]);
    cdiff = (VW+1)'(chk_r[NSH]) - (VW+1)'(v_r[NSH]);
    fmag  = fdiff[VW] ? (VW+1)'(-fdiff) : (VW+1)'(fdiff);
    cmag  = cdiff[VW] ? (VW+1)'(-cdiff) : (VW+1)'(cdiff);
    dok   = {fmag, 8'd0} < (VW+9)'(limit_r);
    cok   = {cmag, 8'd0} < (VW+9)'(limit_r);
    ok    = (case_r[NSH] != CASE_NONE) && dok && big_r[NSH] &&
            (!case_r[NSH][1] || cok);
    res.reference_case     = case_r[NSH];
    res.accepted           = ok;
    res.corrected_velocity = ok ? v_r[NSH][15:0] : 16'sd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= vld_r[NSH];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_r <= res;
    end
  end

  assign out_ch.valid = out_vld_r;
  assign out_ch.data  = out_r;

endmodule
`default_nettype wire

// File: hdl/vcu_checker.sv
`default_nettype none
module vcu_checker (
  input wire        clk,
  input wire        rst_n,
  input wire        in_ready,
  input wire        out_valid,
  input wire        out_ready,
  input wire [15:0] out_velocity,
  input wire        out_accepted,
  input wire [1:0]  out_case
);
  import vcu_pkg::*;

  // result held until transfer
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_velocity) &&
    $stable(out_accepted) && $stable(out_case))
    else $error("result changed while stalled");

  a_ready_flow: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready == (!out_valid || out_ready))
    else $error("input ready does not follow output stall");

  a_none_rejected: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_case == CASE_NONE) |-> !out_accepted)
    else $error("gate accepted without reference");

  a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_accepted |-> out_velocity == 16'd0)
    else $error("rejected gate carries a velocity");

endmodule

bind velocity_continuity_unfold vcu_checker u_vcu_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .out_velocity (out_ch.data.corrected_velocity),
  .out_accepted (out_ch.data.accepted),
  .out_case     (out_ch.data.reference_case)
);
`default_nettype wire

// File: sim/tb_velocity_continuity_unfold.sv
`timescale 1ns / 1ps
`default_nettype none
module tb_velocity_continuity_unfold;
  import vcu_pkg::*;

  localparam int     MAX_SHIFTS = 10;
  localparam int     VEL_BITS   = 16;
  localparam longint VEL_MAX    = (longint'(1) <<< (VEL_BITS - 1)) - 1;
  localparam longint VEL_MIN    = -VEL_MAX - 1;
  localparam int     PIPE_LAT   = MAX_SHIFTS + 2;
  localparam int     LONG_HOLD  = 160;

  // register indexes past the end of the map, writes there must do nothing
  localparam logic [2:0] CFG_SPARE_LO = 3'd5;
  localparam logic [2:0] CFG_SPARE_HI = 3'd7;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [15:0] cfg_data;

  vcu_in_if  in_ch ();
  vcu_out_if out_ch ();

  velocity_continuity_unfold #(
    .MAX_SHIFTS    (MAX_SHIFTS),
    .VELOCITY_BITS (VEL_BITS)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // shadow copy of the configuration registers
  logic signed [15:0] miss_code = RST_MISSING_CODE;
  logic [13:0]        nyq_vel   = RST_NYQUIST_VEL;
  logic [14:0]        nyq_int   = RST_NYQUIST_INT;
  logic [8:0]         cmp_frac  = RST_COMPARE_FRAC;
  logic [14:0]        min_abs   = RST_MIN_ABS_VEL;

  out_item_t expected_gates[$];

  bit idle_on       = 1'b1;
  bit long_hold_req = 1'b0;
  int errors        = 0;
  int gates_sent    = 0;
  int results_seen  = 0;
  int gates_accepted = 0;
  int case_hits[4]  = '{0, 0, 0, 0};
  int reg_writes    = 0;
  int settings_used = 0;
  int longest_hold  = 0;

  initial clk = 1'b0;
  always #6 clk = ~clk;

  initial begin
    #5_000_000;
    $display("FAIL");
    $finish;
  end

  function automatic longint mag(longint x);
    return (x < 0) ? -x : x;
  endfunction

  function automatic logic signed [15:0] clip16(longint x);
    if (x > VEL_MAX) return VEL_MAX[15:0];
    if (x < VEL_MIN) return VEL_MIN[15:0];
    return x[15:0];
  endfunction

  function automatic out_item_t unfold_gate(in_item_t g);
    out_item_t  r;
    longint     obs, miss, prv, snd, abv, refv, v, d, lim, vn, stp;
    logic [1:0] gcase;
    bit         ok;
    int         n;
    r = '0;
    obs = $signed(g.observed_velocity);
    miss = miss_code;
    if (obs == miss) return r;
    prv = g.previous_present ? longint'($signed(g.previous_velocity)) : miss;
    snd = (g.sounding_present && !g.previous_present) ?
          longint'($signed(g.sounding_velocity)) : miss;
    abv = g.above_present ? longint'($signed(g.above_velocity)) : miss;
    gcase = CASE_NONE;
    refv = 0;
    if (!g.previous_present && snd != miss && abv == miss) begin
      refv = snd;
      gcase = CASE_SOUNDING;
    end else if (!g.previous_present && snd != miss) begin
      refv = abv;
      gcase = CASE_ABOVE;
    end else if (prv != miss && abv != miss) begin
      refv = prv;
      gcase = CASE_PREVIOUS;
    end
    r.reference_case = gcase;
    if (gcase == CASE_NONE) return r;
    vn = longint'(nyq_vel);
    stp = longint'(nyq_int);
    v = obs;
    d = mag(refv - v);
    for (n = 0; n <= MAX_SHIFTS && d >= vn; n++) begin
      v = clip16((refv >= v) ? v + stp : v - stp);
      d = mag(refv - v);
    end
    lim = longint'(cmp_frac) * vn;
    ok = (d * 256 < lim) && (mag(obs) > longint'(min_abs));
    if (gcase == CASE_ABOVE) ok = ok && (mag(snd - v) * 256 < lim);
    if (gcase == CASE_PREVIOUS) ok = ok && (mag(abv - v) * 256 < lim);
    if (ok) begin
      r.corrected_velocity = v[15:0];
      r.accepted = 1'b1;
    end
    return r;
  endfunction

  function automatic longint wobble(longint thr);
    longint span;
    span = ($urandom_range(0, 7) == 0) ? 4 * thr : thr;
    return longint'($urandom_range(0, 32'(2 * span))) - span;
  endfunction

  // mostly plausible gates: a true velocity, its folded observation and
  // references scattered around the acceptance threshold
  function automatic in_item_t make_gate();
    in_item_t g;
    longint   vn, stp, thr, t, o;
    int       pick;
    vn = longint'(nyq_vel);
    stp = longint'(nyq_int);
    thr = (longint'(cmp_frac) * vn) >>> 8;
    g.observed_velocity = 16'($urandom);
    g.previous_velocity = 16'($urandom);
    g.sounding_velocity = 16'($urandom);
    g.above_velocity    = 16'($urandom);
    g.previous_present  = 1'($urandom);
    g.sounding_present  = 1'($urandom);
    g.above_present     = 1'($urandom);
    pick = $urandom_range(0, 99);
    if (pick >= 15) begin
      if (pick < 25 || vn == 0) t = $signed(16'($urandom));
      else t = longint'($urandom_range(0, 32'(6 * vn))) - 3 * vn;
      o = t;
      if (stp != 0) begin
        o = (t + vn) % stp;
        if (o < 0) o = o + stp;
        o = o - vn;
      end
      g.observed_velocity = clip16(o);
      g.previous_velocity = clip16(t + wobble(thr));
      g.sounding_velocity = clip16(t + wobble(thr));
      g.above_velocity    = clip16(t + wobble(thr));
      g.previous_present  = ($urandom_range(0, 1) == 0);
      g.sounding_present  = ($urandom_range(0, 9) < 7);
      g.above_present     = ($urandom_range(0, 9) < 6);
      case ($urandom_range(0, 19))
        0: g.previous_velocity = miss_code;
        1: g.sounding_velocity = miss_code;
        2: g.above_velocity = miss_code;
        3: g.observed_velocity = miss_code;
        default: ;
      endcase
    end
    return g;
  endfunction

  function automatic in_item_t gate_of(longint o, longint pv, longint sv, longint av,
                                       bit pp, bit sp, bit ap);
    in_item_t g;
    g.observed_velocity = o[15:0];
    g.previous_velocity = pv[15:0];
    g.sounding_velocity = sv[15:0];
    g.above_velocity    = av[15:0];
    g.previous_present  = pp;
    g.sounding_present  = sp;
    g.above_present     = ap;
    return g;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    errors++;
    $display("mismatch at %0t: %s, got %0d expected %0d", $time, what, got, want);
  endtask

  // one input transfer, valid stays up afterwards unless a gap or settle drops it
  task automatic send_gate(in_item_t g);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= g;
    do @(posedge clk); while (!in_ch.ready);
    expected_gates.push_back(unfold_gate(g));
    gates_sent++;
  endtask

  task automatic write_reg(logic [2:0] idx, logic [15:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    reg_writes++;
    case (idx)
      CFG_MISSING_CODE: miss_code = val;
      CFG_NYQUIST_VEL:  nyq_vel = val[13:0];
      CFG_NYQUIST_INT:  nyq_int = val[14:0];
      CFG_COMPARE_FRAC: cmp_frac = val[8:0];
      CFG_MIN_ABS_VEL:  min_abs = val[14:0];
      default: ;
    endcase
  endtask

  task automatic apply_setting(logic [15:0] mc, logic [15:0] vn, logic [15:0] ni,
                               logic [15:0] cf, logic [15:0] mv);
    write_reg(CFG_MISSING_CODE, mc);
    write_reg(CFG_NYQUIST_VEL, vn);
    write_reg(CFG_NYQUIST_INT, ni);
    write_reg(CFG_COMPARE_FRAC, cf);
    write_reg(CFG_MIN_ABS_VEL, mv);
    settings_used++;
  endtask

  task automatic settle();
    in_ch.valid <= 1'b0;
    while (expected_gates.size() != 0) @(posedge clk);
    repeat (PIPE_LAT + 4) @(posedge clk);
  endtask

  task automatic send_random(int count);
    repeat (count) send_gate(make_gate());
  endtask

  // reset defaults: missing -32768, nyquist 1000, interval 2000, threshold 250 cm/s
  task automatic test_directed();
    send_gate(gate_of(-32768, 10, 10, 10, 1, 1, 1));
    send_gate(gate_of(-1500, 0, 500, 0, 0, 1, 0));
    send_gate(gate_of(1800, 0, -180, -150, 0, 1, 1));
    send_gate(gate_of(1800, 0, 600, -150, 0, 1, 1));
    send_gate(gate_of(-1900, 120, 0, 90, 1, 1, 1));
    send_gate(gate_of(-1900, 120, 0, 900, 1, 1, 1));
    send_gate(gate_of(700, 700, 700, 700, 0, 0, 0));
    send_gate(gate_of(700, 700, 0, -32768, 1, 0, 1));
    send_gate(gate_of(700, 0, 700, 0, 1, 1, 0));
    send_gate(gate_of(700, 0, -32768, 0, 0, 1, 0));
    send_gate(gate_of(31000, 32767, 0, 32767, 1, 0, 1));
    send_gate(gate_of(-31000, 0, -32767, 0, 0, 1, 0));
    send_gate(gate_of(-30000, 30000, 0, 30000, 1, 0, 1));
    send_gate(gate_of(0, 0, 1000, 0, 0, 1, 0));
    send_gate(gate_of(100, 0, 100, 0, 0, 1, 0));
    send_gate(gate_of(101, 0, 101, 0, 0, 1, 0));
    send_gate(gate_of(-101, 0, -101, 0, 0, 1, 0));
    send_gate(gate_of(32767, 0, -32767, 0, 0, 1, 0));
    send_gate(gate_of(300, 0, 50, 0, 0, 1, 0));
    send_gate(gate_of(300, 0, 51, 0, 0, 1, 0));
    send_gate(gate_of(500, -32768, 500, 500, 1, 1, 1));
    send_gate(gate_of(-32767, 32767, -32767, 32767, 1, 1, 1));
    send_gate(gate_of(16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 0, 1, 1));
    send_gate(gate_of(16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 1, 0, 1));
    settle();
  endtask

  task automatic test_register_extremes();
    apply_setting(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_random(25);
    settle();
    apply_setting(16'h7FFF, 16'd16383, 16'd32767, 16'd256, 16'd0);
    send_random(25);
    settle();
    apply_setting(16'h0000, 16'd1, 16'd1, 16'd256, 16'd0);
    send_random(25);
    settle();
    // zero nyquist velocity and zero interval lie outside the usual range
    apply_setting(16'h8000, 16'd0, 16'd0, 16'd256, 16'd0);
    send_random(20);
    settle();
    apply_setting(16'h8000, 16'd0, 16'd2000, 16'd0, 16'd0);
    send_random(20);
    settle();
    apply_setting(16'hFC19, 16'd100, 16'd0, 16'd200, 16'd10);
    send_random(20);
    settle();
    apply_setting(16'h8000, 16'd2500, 16'd5000, 16'd128, 16'd50);
    write_reg(CFG_SPARE_LO, 16'hFFFF);
    write_reg(CFG_SPARE_HI, 16'h0000);
    send_random(30);
    settle();
  endtask

  task automatic test_random_settings();
    int          p;
    logic [15:0] vn, ni, cf;
    for (p = 0; p < 6; p++) begin
      vn = (p == 5) ? 16'($urandom_range(4000, 16383)) : 16'($urandom_range(50, 4000));
      ni = ($urandom_range(0, 3) != 0) ? 16'(2 * vn) : 16'($urandom_range(1, 32767));
      cf = ($urandom_range(0, 5) == 0) ? 16'($urandom) : 16'($urandom_range(0, 256));
      apply_setting(($urandom_range(0, 1) == 0) ? 16'h8000 : 16'($urandom), vn, ni, cf,
                    16'($urandom_range(0, 400)));
      send_random(140);
      settle();
    end
  endtask

  task automatic test_output_hold();
    long_hold_req = 1'b1;
    send_random(48);
    settle();
  endtask

  task automatic test_full_rate();
    idle_on = 1'b0;
    apply_setting(16'h8000, 16'd1000, 16'd2000, 16'd96, 16'd50);
    send_random(250);
    settle();
  endtask

  initial begin : out_ready_gen
    int n;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold_req) begin
        out_ch.ready <= 1'b0;
        for (n = 0; n < LONG_HOLD; n++) @(posedge clk);
        if (n > longest_hold) longest_hold = n;
        long_hold_req = 1'b0;
        out_ch.ready <= 1'b1;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk);
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : check_results
    out_item_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      results_seen++;
      if (expected_gates.size() == 0) begin
        report_mismatch("result with nothing expected", out_ch.data.corrected_velocity, 0);
      end else begin
        want = expected_gates.pop_front();
        if (out_ch.data.corrected_velocity !== want.corrected_velocity)
          report_mismatch("corrected_velocity", out_ch.data.corrected_velocity,
                          want.corrected_velocity);
        if (out_ch.data.accepted !== want.accepted)
          report_mismatch("accepted", out_ch.data.accepted, want.accepted);
        if (out_ch.data.reference_case !== want.reference_case)
          report_mismatch("reference_case", out_ch.data.reference_case,
                          want.reference_case);
        if (want.accepted) gates_accepted++;
        case_hits[want.reference_case]++;
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_register_extremes();
    test_random_settings();
    test_output_hold();
    test_full_rate();
    if (expected_gates.size() != 0)
      report_mismatch("expectations left over", expected_gates.size(), 0);
    $display("checked %0d results from %0d gates under %0d register settings (%0d writes)",
             results_seen, gates_sent, settings_used, reg_writes);
    $display("accepted %0d; cases none/sounding/above/previous %0d/%0d/%0d/%0d; hold %0d cycles",
             gates_accepted, case_hits[0], case_hits[1], case_hits[2], case_hits[3],
             longest_hold);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
`default_nettype wire

// File: filelist.f
hdl/vcu_pkg.sv
hdl/vcu_if.sv
hdl/velocity_continuity_unfold.sv
hdl/vcu_checker.sv
sim/tb_velocity_continuity_unfold.sv
